// ===== hw/rtl/bsps_pkg.sv =====
package bsps_pkg;

    localparam int IDX_W    = 7;
    localparam int VAL_W    = 32;
    localparam int RES_W    = 38;
    localparam int ACC_W    = 64;

    typedef enum logic [2:0] {
        MODE_INSERT = 3'd0,
        MODE_INC    = 3'd1,
        MODE_DEC    = 3'd2,
        MODE_SET    = 3'd3,
        MODE_GET    = 3'd4,
        MODE_PREFIX = 3'd5,
        MODE_FIND   = 3'd6,
        MODE_CLEAR  = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_INSERT = 2'd1,
        OP_WRITE  = 2'd2,
        OP_CLEAR  = 2'd3
    } store_op_t;

    typedef struct packed {
        store_op_t          op;
        logic [IDX_W-1:0]   addr;
        logic [ACC_W-1:0]   data;
    } store_cmd_t;

endpackage

// ===== hw/rtl/bit_sliced_prefix_sum_leaf_top.sv =====
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_ready  mode, index, value
// out      output     out_valid/out_ready  result, entry_count, overflow, full_error
//
// Insert, increment, decrement, set, get and clear go from acceptance through
// the execute state to the done state, where the result is valid.
// Prefix sum and find pass through the scan state instead, where one shared
// 64-bit adder walks the entries one per cycle.
// One item is held at a time; in_ready returns after the result is taken.
// rst_n clears the store, the count and all control state.
module bit_sliced_prefix_sum_leaf_top
    import bsps_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int ENTRIES    = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        mode,
    input  logic [IDX_W-1:0]  index,
    input  logic [VAL_W-1:0]  value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [RES_W-1:0]  result,
    output logic [IDX_W-1:0]  entry_count,
    output logic              overflow,
    output logic              full_error
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    mode_t              mode_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [VAL_W-1:0]   val_reg;
    logic [IDX_W-1:0]   count_reg, count_next;
    logic [RES_W-1:0]   res_reg, res_next;
    logic               ovf_reg, ovf_next;
    logic               full_reg, full_next;

    store_cmd_t              cmd;
    logic [IDX_W-1:0]        rd_addr;
    logic [VALUE_BITS-1:0]   entry;
    logic                    scan_start;
    logic [IDX_W-1:0]        scan_addr;
    logic                    scan_done;
    logic [RES_W-1:0]        scan_result;
    logic [IDX_W-1:0]        limit;
    logic                    ok;
    logic [ACC_W-1:0]        e64;
    logic [ACC_W-1:0]        v64;
    logic [ACC_W:0]          inc_sum;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_DONE);
    assign result      = res_reg;
    assign entry_count = count_reg;
    assign overflow    = ovf_reg;
    assign full_error  = full_reg;

    assign ok      = idx_reg < IDX_W'(ENTRIES);
    assign limit   = (idx_reg > IDX_W'(ENTRIES)) ? IDX_W'(ENTRIES) : idx_reg;
    assign rd_addr = (state_reg == S_SCAN) ? scan_addr : idx_reg;
    assign e64     = ACC_W'(entry);
    assign v64     = ACC_W'(val_reg);
    assign inc_sum = {1'b0, e64} + {1'b0, v64};

    bsps_store #(
        .VALUE_BITS (VALUE_BITS),
        .ENTRIES    (ENTRIES)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .rd_data (entry)
    );

    bsps_scan #(
        .VALUE_BITS (VALUE_BITS),
        .ENTRIES    (ENTRIES)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (scan_start),
        .find   (mode_reg == MODE_FIND),
        .limit  (limit),
        .target (val_reg),
        .entry  (entry),
        .addr   (scan_addr),
        .done   (scan_done),
        .result (scan_result)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        res_next   = res_reg;
        ovf_next   = ovf_reg;
        full_next  = full_reg;
        scan_start = 1'b0;
        cmd.op     = OP_NONE;
        cmd.addr   = idx_reg;
        cmd.data   = v64;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_next   = '0;
                ovf_next   = 1'b0;
                full_next  = 1'b0;
                state_next = S_DONE;
                case (mode_reg)
                    MODE_INSERT:
                    begin
                        if (count_reg >= IDX_W'(ENTRIES))
                        begin
                            full_next = 1'b1;
                        end
                        else if (ok)
                        begin
                            cmd.op     = OP_INSERT;
                            count_next = count_reg + IDX_W'(1);
                        end
                    end
                    MODE_INC:
                    begin
                        if (ok)
                        begin
                            cmd.op   = OP_WRITE;
                            cmd.data = inc_sum[ACC_W-1:0];
                            ovf_next = |inc_sum[ACC_W:VALUE_BITS];
                        end
                    end
                    MODE_DEC:
                    begin
                        if (ok)
                        begin
                            cmd.op   = OP_WRITE;
                            cmd.data = e64 - v64;
                        end
                    end
                    MODE_SET:
                    begin
                        if (ok)
                        begin
                            cmd.op = OP_WRITE;
                        end
                    end
                    MODE_GET:
                    begin
                        if (ok)
                        begin
                            res_next = e64[RES_W-1:0];
                        end
                    end
                    MODE_PREFIX, MODE_FIND:
                    begin
                        scan_start = 1'b1;
                        state_next = S_SCAN;
                    end
                    MODE_CLEAR:
                    begin
                        cmd.op     = OP_CLEAR;
                        count_next = '0;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    res_next   = scan_result;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg <= mode_t'(mode);
            idx_reg  <= index;
            val_reg  <= value;
        end
        res_reg  <= res_next;
        ovf_reg  <= ovf_next;
        full_reg <= full_next;
    end

endmodule

// ===== hw/rtl/bsps_store.sv =====
module bsps_store
    import bsps_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int ENTRIES    = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  store_cmd_t            cmd,
    input  logic [IDX_W-1:0]      rd_addr,
    output logic [VALUE_BITS-1:0] rd_data
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [ENTRIES-1:0] plane_reg  [VALUE_BITS];
    logic [ENTRIES-1:0] plane_next [VALUE_BITS];
    logic [ENTRIES-1:0] lo_mask;
    logic [ENTRIES-1:0] pos_bit;

    always_comb
    begin
        pos_bit = '0;
        pos_bit[cmd.addr[AW-1:0]] = 1'b1;
        lo_mask = pos_bit - ENTRIES'(1);
    end

    always_comb
    begin
        for (int k = 0; k < VALUE_BITS; k++)
        begin
            rd_data[k] = plane_reg[k][rd_addr[AW-1:0]];
            case (cmd.op)
                OP_INSERT:
                    plane_next[k] = (plane_reg[k] & lo_mask)
                                  | ((plane_reg[k] & ~lo_mask) << 1)
                                  | (cmd.data[k] ? pos_bit : '0);
                OP_WRITE:
                    plane_next[k] = (plane_reg[k] & ~pos_bit)
                                  | (cmd.data[k] ? pos_bit : '0);
                OP_CLEAR:
                    plane_next[k] = '0;
                default:
                    plane_next[k] = plane_reg[k];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < VALUE_BITS; k++)
            begin
                plane_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < VALUE_BITS; k++)
            begin
                plane_reg[k] <= plane_next[k];
            end
        end
    end

endmodule

// ===== hw/rtl/bsps_scan.sv =====
module bsps_scan
    import bsps_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int ENTRIES    = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  find,
    input  logic [IDX_W-1:0]      limit,
    input  logic [VAL_W-1:0]      target,
    input  logic [VALUE_BITS-1:0] entry,
    output logic [IDX_W-1:0]      addr,
    output logic                  done,
    output logic [RES_W-1:0]      result
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [IDX_W-1:0]    k_reg, k_next;
    logic [IDX_W-1:0]    best_reg, best_next;
    logic [ACC_W-1:0]    p_reg, p_next;
    logic [ACC_W-1:0]    q_reg, q_next;
    logic [ACC_W-1:0]    sum;
    logic [ACC_W-1:0]    tgt;

    assign tgt  = ACC_W'(target);
    assign sum  = p_reg + ACC_W'(entry);
    assign addr = k_reg;
    assign done = done_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        k_next    = k_reg;
        best_next = best_reg;
        p_next    = p_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            k_next    = '0;
            best_next = '0;
            p_next    = '0;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (find)
            begin
                if (k_reg == '0 || p_reg < tgt)
                begin
                    best_next = k_reg;
                    q_next    = sum;
                end
                p_next = sum;
            end
            else if (k_reg < limit)
            begin
                p_next = sum;
            end
            k_next = k_reg + IDX_W'(1);
            if (k_reg == IDX_W'(ENTRIES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (find)
        begin
            result = RES_W'(best_reg) + RES_W'(q_reg <= tgt);
        end
        else
        begin
            result = p_reg[RES_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        p_reg    <= p_next;
        q_reg    <= q_next;
    end

endmodule

// ===== hw/rtl/bsps_checker.sv =====
module bsps_checker
    import bsps_pkg::*;
#(
    parameter int ENTRIES = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [RES_W-1:0]  result,
    input  logic [IDX_W-1:0]  entry_count,
    input  logic              overflow,
    input  logic              full_error
);

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready stayed high after an item was accepted");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (entry_count <= IDX_W'(ENTRIES)))
        else $error("entry count above capacity");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(overflow && full_error))
        else $error("overflow and full error both set");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(result)))
        else $error("result changed while stalled");

endmodule

bind bit_sliced_prefix_sum_leaf_top bsps_checker #(
    .ENTRIES (ENTRIES)
) u_bsps_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result      (result),
    .entry_count (entry_count),
    .overflow    (overflow),
    .full_error  (full_error)
);
